/* rtl/ttcw_pkg.sv */
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types and constants of the text terminal character writer.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam logic [FUNC_W-1:0] OP_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_MOVE  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] OP_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture input item
    logic exec;      // perform the operation
    logic fill_row;  // write a space into the cursor row, column from counter
    logic fill_all;  // write a space at the linear counter address
    logic cap_read;  // capture memory read data
    logic load_out;  // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              newline;   // current put ends in a newline
    logic              row_last;  // counter at last column
    logic              all_last;  // counter at last cell
  } sts_t;

endpackage

/* rtl/ttcw_ctrl.sv */
// ----------------------------------------------------------------------------
// ttcw_ctrl
// Sequencer: item accept, operation steps, row and screen fills, result hold.
// ----------------------------------------------------------------------------
module ttcw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ttcw_pkg::sts_t sts,
  output ttcw_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_FILL_ROW = 3'd2;
  localparam logic [2:0] ST_FILL_ALL = 3'd3;
  localparam logic [2:0] ST_RDWAIT   = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       pend_r, pend_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.func == ttcw_pkg::OP_CLEAR) state_nxt = ST_FILL_ALL;
        else if (sts.newline)                state_nxt = ST_FILL_ROW;
        else if (sts.func == ttcw_pkg::OP_READ) state_nxt = ST_RDWAIT;
        else                                 state_nxt = ST_DONE;
      end
      ST_FILL_ROW: begin
        cmd.fill_row = 1'b1;
        if (sts.row_last) state_nxt = ST_DONE;
      end
      ST_FILL_ALL: begin
        cmd.fill_all = 1'b1;
        // the pass after reset has no item to report
        if (sts.all_last) state_nxt = pend_r ? ST_DONE : ST_IDLE;
      end
      ST_RDWAIT: begin
        cmd.cap_read = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)                  out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    pend_nxt = pend_r;
    if (cmd.latch)         pend_nxt = 1'b1;
    else if (cmd.load_out) pend_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL_ALL;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/ttcw_dp.sv */
// ----------------------------------------------------------------------------
// ttcw_dp
// Datapath: screen memory with circular row offset, cursor, result registers.
// ----------------------------------------------------------------------------
module ttcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ttcw_pkg::cmd_t                cmd,
  output ttcw_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic                          cfg_data,
  input  logic [ttcw_pkg::FUNC_W-1:0]   in_func,
  input  logic [ttcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [ttcw_pkg::COL_W-1:0]    in_column,
  input  logic [ttcw_pkg::ROW_W-1:0]    in_row,
  output logic                          out_uart_valid,
  output logic [ttcw_pkg::CHAR_W-1:0]   out_uart_char,
  output logic [ttcw_pkg::COL_W-1:0]    out_cursor_column,
  output logic [ttcw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [ttcw_pkg::CHAR_W-1:0]   out_cell_char,
  output logic                          out_scrolled
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [ttcw_pkg::FUNC_W-1:0] func_r;
  logic [ttcw_pkg::CHAR_W-1:0] char_r;
  logic [ttcw_pkg::COL_W-1:0]  col_r;
  logic [ttcw_pkg::ROW_W-1:0]  row_r;

  logic          echo_r;
  logic [CW-1:0] cursor_col_r;
  logic [RW-1:0] cursor_line_r;
  logic [RW-1:0] top_r;      // physical row shown as logical row 0
  logic [AW-1:0] cnt_r;

  logic                        res_uart_valid_r;
  logic [ttcw_pkg::CHAR_W-1:0] res_uart_char_r;
  logic [ttcw_pkg::CHAR_W-1:0] res_cell_r;
  logic                        res_scrolled_r;

  logic                        out_uart_valid_r;
  logic [ttcw_pkg::CHAR_W-1:0] out_uart_char_r;
  logic [ttcw_pkg::COL_W-1:0]  out_col_r;
  logic [ttcw_pkg::ROW_W-1:0]  out_row_r;
  logic [ttcw_pkg::CHAR_W-1:0] out_cell_r;
  logic                        out_scrolled_r;

  logic [ttcw_pkg::CHAR_W-1:0] mem [CELLS];
  logic [ttcw_pkg::CHAR_W-1:0] rd_q;

  logic          is_put, is_plain, at_last_col, at_last_row;
  logic [CW-1:0] col_clamp, col_sel;
  logic [RW-1:0] row_clamp, row_sel, phys_row;
  logic [RW:0]   row_sum;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [ttcw_pkg::CHAR_W-1:0] mem_wd;

  assign is_put   = (func_r == ttcw_pkg::OP_PUT);
  assign is_plain = (char_r != ttcw_pkg::CH_CR) && (char_r != ttcw_pkg::CH_LF) &&
                    (char_r != ttcw_pkg::CH_BS);
  assign at_last_col = (cursor_col_r == CW'(COLUMNS - 1));
  assign at_last_row = (cursor_line_r == RW'(ROWS - 1));

  assign col_clamp = (32'(col_r) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(col_r);
  assign row_clamp = (32'(row_r) >= ROWS) ? RW'(ROWS - 1) : RW'(row_r);

  always_comb begin
    if (cmd.fill_row) begin
      row_sel = cursor_line_r;
      col_sel = cnt_r[CW-1:0];
    end else if (func_r == ttcw_pkg::OP_READ) begin
      row_sel = row_clamp;
      col_sel = col_clamp;
    end else begin
      row_sel = cursor_line_r;
      col_sel = cursor_col_r;
    end
  end

  // logical row -> physical row through the scroll offset
  assign row_sum  = {1'b0, row_sel} + {1'b0, top_r};
  assign phys_row = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS))
                                               : RW'(row_sum);

  always_comb begin
    if (cmd.fill_all) mem_addr = cnt_r;
    else              mem_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(col_sel);
    mem_we = cmd.fill_all || cmd.fill_row || (cmd.exec && is_put && is_plain);
    mem_wd = (cmd.fill_all || cmd.fill_row) ? ttcw_pkg::CH_SPACE : char_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_q <= mem[mem_addr];
  end

  assign sts.func     = func_r;
  assign sts.newline  = is_put && ((char_r == ttcw_pkg::CH_LF) || (is_plain && at_last_col));
  assign sts.row_last = (cnt_r[CW-1:0] == CW'(COLUMNS - 1));
  assign sts.all_last = (cnt_r == AW'(CELLS - 1));

  // item capture and payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      char_r <= in_char_code;
      col_r  <= in_column;
      row_r  <= in_row;
    end
    if (cmd.exec) begin
      res_uart_valid_r <= is_put && echo_r;
      res_uart_char_r  <= (is_put && echo_r) ? char_r : '0;
      res_cell_r       <= '0;
      res_scrolled_r   <= sts.newline && at_last_row;
    end
    if (cmd.cap_read) res_cell_r <= rd_q;
    if (cmd.load_out) begin
      out_uart_valid_r <= res_uart_valid_r;
      out_uart_char_r  <= res_uart_char_r;
      out_col_r        <= ttcw_pkg::COL_W'(cursor_col_r);
      out_row_r        <= ttcw_pkg::ROW_W'(cursor_line_r);
      out_cell_r       <= res_cell_r;
      out_scrolled_r   <= res_scrolled_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r        <= 1'b1;
      cursor_col_r  <= '0;
      cursor_line_r <= '0;
      top_r         <= '0;
      cnt_r         <= '0;
    end else begin
      if (cfg_we) echo_r <= cfg_data;
      if (cmd.exec) cnt_r <= '0;
      else if (cmd.fill_row || cmd.fill_all) cnt_r <= cnt_r + 1'b1;
      if (cmd.exec) begin
        if (sts.newline) begin
          cursor_col_r <= '0;
          if (at_last_row) top_r <= (top_r == RW'(ROWS - 1)) ? '0 : top_r + 1'b1;
          else             cursor_line_r <= cursor_line_r + 1'b1;
        end else if (is_put && is_plain) begin
          cursor_col_r <= cursor_col_r + 1'b1;
        end else if (is_put && (char_r == ttcw_pkg::CH_BS)) begin
          if (cursor_col_r != '0) cursor_col_r <= cursor_col_r - 1'b1;
        end else if (func_r == ttcw_pkg::OP_MOVE) begin
          cursor_col_r  <= col_clamp;
          cursor_line_r <= row_clamp;
        end else if (func_r == ttcw_pkg::OP_CLEAR) begin
          top_r <= '0;  // whole screen is rewritten linearly
        end
      end
    end
  end

  assign out_uart_valid    = out_uart_valid_r;
  assign out_uart_char     = out_uart_char_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cell_char     = out_cell_r;
  assign out_scrolled      = out_scrolled_r;

endmodule

/* rtl/text_terminal_char_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_char_writer_unit
// Text-mode console: screen memory, cursor, scrolling, serial echo.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. Through the single-port
// screen memory a plain put, backspace, carriage return or move runs from accept
// through the operation step and the result step; a cell read adds a read-wait
// step. A newline (typed or from wrapping at the last column) adds a pass that
// blanks the new row; scrolling itself is a row-offset update, not a copy. A
// clear adds a pass over all ROWS*COLUMNS cells. After reset a clearing pass
// over all ROWS*COLUMNS cells runs with in_stall high; echo enable writes are taken at
// any time. A finished result waits in the output register while the next
// item is accepted.
module text_terminal_char_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 30
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ttcw_pkg::FUNC_W-1:0] in_func,
  input  logic [ttcw_pkg::CHAR_W-1:0] in_char_code,
  input  logic [ttcw_pkg::COL_W-1:0]  in_column,
  input  logic [ttcw_pkg::ROW_W-1:0]  in_row,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_uart_valid,
  output logic [ttcw_pkg::CHAR_W-1:0] out_uart_char,
  output logic [ttcw_pkg::COL_W-1:0]  out_cursor_column,
  output logic [ttcw_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [ttcw_pkg::CHAR_W-1:0] out_cell_char,
  output logic                        out_scrolled,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);

  ttcw_pkg::cmd_t cmd;
  ttcw_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ttcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_char_code      (in_char_code),
    .in_column         (in_column),
    .in_row            (in_row),
    .out_uart_valid    (out_uart_valid),
    .out_uart_char     (out_uart_char),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_cell_char     (out_cell_char),
    .out_scrolled      (out_scrolled)
  );

  // one item in flight: an accepted transfer blocks the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // clearing pass holds off input right after reset
  a_reset_clear: assert property (@(posedge clk)
    $rose(rst_n) |-> in_stall)
    else $error("input open during clearing pass");

  // a scroll leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |->
      (out_cursor_column == '0) && (out_cursor_row == ttcw_pkg::ROW_W'(ROWS - 1)))
    else $error("scroll with cursor off the last row start");

endmodule
